// ===== hdl/ksds_pkg.sv =====
// ---------------------------------------------------------------------------
// Karplus-Strong dual string package
// Shared types, codes and defaults for the dual string unit.
// ---------------------------------------------------------------------------
`default_nettype none
package ksds_pkg;
   localparam int unsigned MAX_LENGTH_DEF = 4096;
   localparam int unsigned BLOCK_LEN_DEF  = 256;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_START   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_DAMP_A   = 3'd0,
      REG_DAMP_B   = 3'd1,
      REG_FB_A     = 3'd2,
      REG_FB_B     = 3'd3,
      REG_GAIN_A   = 3'd4,
      REG_GAIN_B   = 3'd5,
      REG_INVERT   = 3'd6,
      REG_DECAY    = 3'd7
   } reg_index_type;

   // Commands from the controller to the datapath, one step each.
   typedef struct packed {
      logic load;      // append excitation word
      logic start;     // start note
      logic release_n; // release note
      logic rd;        // issue line reads for a tick
      logic filt;      // lowpass on read data
      logic fbk;       // feedback product, write back
      logic mix;       // mix products
      logic fin;       // release scaling, peak, result
   } ctl_type;
endpackage
`default_nettype wire

// ===== hdl/karplus_strong_dual_string_unit.sv =====
// ---------------------------------------------------------------------------
// Karplus-Strong dual string unit
// Two plucked-string delay loops with damping, mixing and release.
// ---------------------------------------------------------------------------
// A load, release or start word is carried out in the cycle it is accepted
// and its result word is held in the output register; a tick word walks
// through the controller's line read, the lowpass, the feedback product
// and write-back, the mix, and the release scaling. The next word is taken
// once the controller is idle and the output register is free or being
// taken. Both delay lines live in memories of MAX_LENGTH words with one read
// and one write per cycle; entries are written by loads before they are ever
// read, so they need no clearing. Configuration words are taken at any time
// and should be written only while the unit is idle.
`default_nettype none
module karplus_strong_dual_string_unit #(
   parameter int unsigned MAX_LENGTH = ksds_pkg::MAX_LENGTH_DEF,
   parameter int unsigned BLOCK_LEN  = ksds_pkg::BLOCK_LEN_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_cmd,
   input  wire logic                req_unit,
   input  wire logic signed [15:0]  req_excite_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [15:0]       rsp_sample_out,
   output logic                     rsp_finished,
   output logic [15:0]              rsp_level,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [15:0]         csr_data
);
   import ksds_pkg::*;

   ctl_type ctl;
   logic [15:0] damp_a_ff, damp_b_ff, fb_a_ff, fb_b_ff, decay_ff;
   logic signed [15:0] gain_a_ff, gain_b_ff;
   logic [1:0] inv_ff;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         damp_a_ff <= '0; damp_b_ff <= '0; fb_a_ff <= '0; fb_b_ff <= '0;
         gain_a_ff <= 16'sd32767; gain_b_ff <= '0; inv_ff <= '0;
         decay_ff <= 16'd65000;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_DAMP_A: damp_a_ff <= csr_data;
            REG_DAMP_B: damp_b_ff <= csr_data;
            REG_FB_A:   fb_a_ff <= csr_data;
            REG_FB_B:   fb_b_ff <= csr_data;
            REG_GAIN_A: gain_a_ff <= csr_data;
            REG_GAIN_B: gain_b_ff <= csr_data;
            REG_INVERT: inv_ff <= csr_data[1:0];
            REG_DECAY:  decay_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   ksds_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_cmd,
      .rsp_valid, .rsp_stall, .ctl
   );

   // Load and release act in the accept cycle, so the payload goes straight in.
   ksds_datapath #(.MAX_LENGTH(MAX_LENGTH), .BLOCK_LEN(BLOCK_LEN)) u_dp (
      .clock, .reset, .ctl, .unit(req_unit), .excite_value(req_excite_value),
      .damp_a(damp_a_ff), .damp_b(damp_b_ff), .feedback_a(fb_a_ff),
      .feedback_b(fb_b_ff), .gain_a(gain_a_ff), .gain_b(gain_b_ff),
      .invert_mask(inv_ff), .release_decay(decay_ff),
      .sample_out(rsp_sample_out), .finished(rsp_finished), .level(rsp_level)
   );

   // A tick never completes in the cycle its word is accepted.
   a_no_busy_accept: assert property (@(posedge clock) disable iff (reset)
      ctl.rd |=> req_stall) else $error("word accepted during a tick");
   // Only one datapath step is commanded at a time.
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ctl)) else $error("overlapping datapath commands");
   // A finished tick always presents a result.
   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.fin |=> rsp_valid) else $error("tick result missing");
endmodule
`default_nettype wire

// ===== hdl/ksds_datapath.sv =====
// ---------------------------------------------------------------------------
// Dual string datapath
// Line memories, string state, filters, mixer and block statistics.
// ---------------------------------------------------------------------------
`default_nettype none
module ksds_datapath #(
   parameter int unsigned MAX_LENGTH = ksds_pkg::MAX_LENGTH_DEF,
   parameter int unsigned BLOCK_LEN  = ksds_pkg::BLOCK_LEN_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ksds_pkg::ctl_type    ctl,
   input  wire logic                 unit,
   input  wire logic signed [15:0]   excite_value,
   input  wire logic [15:0]          damp_a,
   input  wire logic [15:0]          damp_b,
   input  wire logic [15:0]          feedback_a,
   input  wire logic [15:0]          feedback_b,
   input  wire logic signed [15:0]   gain_a,
   input  wire logic signed [15:0]   gain_b,
   input  wire logic [1:0]           invert_mask,
   input  wire logic [15:0]          release_decay,
   output logic signed [15:0]        sample_out,
   output logic                      finished,
   output logic [15:0]               level
);
   import ksds_pkg::*;

   localparam int AW = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
   localparam int LW = $clog2(MAX_LENGTH + 1);
   localparam int TW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) + 1 : 1;

   logic signed [15:0] mem_a [MAX_LENGTH];
   logic signed [15:0] mem_b [MAX_LENGTH];
   logic signed [15:0] rd_a_ff, rd_b_ff;

   logic [LW-1:0] len_a_ff, len_b_ff;
   logic [AW-1:0] pos_a_ff, pos_b_ff;
   logic signed [15:0] lp_a_ff, lp_b_ff;
   logic act_a_ff, act_b_ff;
   logic signed [16:0] y_a_ff, y_b_ff;
   logic signed [33:0] mix_ff;
   logic [16:0] rgain_ff;
   logic released_ff, silent_ff;
   logic [15:0] bpeak_ff, lpeak_ff;
   logic [TW-1:0] tick_ff;
   logic signed [15:0] sample_ff;

   // Position used for the read: wraps to zero when at or beyond the length.
   logic [AW-1:0] rp_a, rp_b;
   always_comb begin
      rp_a = (LW'(pos_a_ff) >= len_a_ff) ? '0 : pos_a_ff;
      rp_b = (LW'(pos_b_ff) >= len_b_ff) ? '0 : pos_b_ff;
   end

   // Lowpass: ((65536-d)*raw + d*lp + 2^15) >> 16
   function automatic logic signed [15:0] lowpass(input logic [15:0] d,
      input logic signed [15:0] x, input logic signed [15:0] lp);
      logic signed [35:0] acc;
      acc = $signed({1'b0, 17'(17'h10000 - {1'b0, d})}) * x
          + $signed({1'b0, d}) * lp + 36'sd32768;
      return acc[31:16];
   endfunction

   function automatic logic signed [16:0] fbmul(input logic [15:0] f,
      input logic signed [15:0] lp);
      logic signed [33:0] acc;
      acc = $signed({1'b0, f}) * lp + 34'sd32768;
      return acc[32:16];
   endfunction

   function automatic logic signed [15:0] wsat(input logic signed [16:0] y,
      input logic inv);
      logic signed [17:0] w;
      w = inv ? -18'(y) : 18'(y);
      if (w > 18'sd32767) return 16'sh7fff;
      else if (w < -18'sd32768) return 16'sh8000;
      else return w[15:0];
   endfunction

   logic signed [15:0] lpn_a, lpn_b;
   logic signed [16:0] yn_a, yn_b;
   logic signed [33:0] pa, pb;
   logic signed [18:0] v15;
   logic signed [36:0] vr;
   logic signed [20:0] v16;
   logic signed [15:0] sat;
   logic [15:0] mag;
   logic [32:0] dec;
   always_comb begin
      lpn_a = lowpass(damp_a, rd_a_ff, lp_a_ff);
      lpn_b = lowpass(damp_b, rd_b_ff, lp_b_ff);
      yn_a  = fbmul(feedback_a, lp_a_ff);
      yn_b  = fbmul(feedback_b, lp_b_ff);
      pa = act_a_ff ? 34'(gain_a * y_a_ff) : '0;
      pb = act_b_ff ? 34'(gain_b * y_b_ff) : '0;
      v15 = 19'((mix_ff + 34'sd16384) >>> 15);
      vr  = v15 * $signed({1'b0, rgain_ff}) + 37'sd32768;
      v16 = vr[36:16];
      if (v16 > 21'sd32767) sat = 16'sh7fff;
      else if (v16 < -21'sd32768) sat = 16'sh8000;
      else sat = v16[15:0];
      mag = sat[15] ? 16'(-17'(sat)) : 16'(sat);
      dec = rgain_ff * release_decay;
   end

   always_ff @(posedge clock) begin
      if (ctl.load && !unit && len_a_ff < LW'(MAX_LENGTH))
         mem_a[len_a_ff[AW-1:0]] <= excite_value;
      else if (ctl.fbk && act_a_ff)
         mem_a[rp_a] <= wsat(yn_a, invert_mask[0]);
      if (ctl.load && unit && len_b_ff < LW'(MAX_LENGTH))
         mem_b[len_b_ff[AW-1:0]] <= excite_value;
      else if (ctl.fbk && act_b_ff)
         mem_b[rp_b] <= wsat(yn_b, invert_mask[1]);
      rd_a_ff <= mem_a[rp_a];
      rd_b_ff <= mem_b[rp_b];
      if (ctl.fbk) begin
         y_a_ff <= yn_a;
         y_b_ff <= yn_b;
      end
      if (ctl.mix) mix_ff <= pa + pb;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.start) begin
         len_a_ff <= '0; len_b_ff <= '0; pos_a_ff <= '0; pos_b_ff <= '0;
         lp_a_ff <= '0; lp_b_ff <= '0; rgain_ff <= 17'h10000;
         released_ff <= 1'b0; silent_ff <= 1'b0; bpeak_ff <= '0;
         lpeak_ff <= '0; tick_ff <= '0; act_a_ff <= 1'b0; act_b_ff <= 1'b0;
         sample_ff <= '0;
      end else begin
         if (ctl.load) begin
            sample_ff <= '0;
            if (!unit && len_a_ff < LW'(MAX_LENGTH)) len_a_ff <= len_a_ff + 1'b1;
            if (unit && len_b_ff < LW'(MAX_LENGTH)) len_b_ff <= len_b_ff + 1'b1;
         end
         if (ctl.release_n) begin
            released_ff <= 1'b1;
            sample_ff <= '0;
         end
         if (ctl.rd) begin
            act_a_ff <= (len_a_ff != '0) && (gain_a != '0);
            act_b_ff <= (len_b_ff != '0) && (gain_b != '0);
         end
         if (ctl.filt) begin
            if (act_a_ff) lp_a_ff <= lpn_a;
            if (act_b_ff) lp_b_ff <= lpn_b;
         end
         if (ctl.fbk) begin
            if (act_a_ff)
               pos_a_ff <= ((LW+1)'(rp_a) + 1'b1 >= (LW+1)'(len_a_ff)) ? '0 : rp_a + 1'b1;
            if (act_b_ff)
               pos_b_ff <= ((LW+1)'(rp_b) + 1'b1 >= (LW+1)'(len_b_ff)) ? '0 : rp_b + 1'b1;
         end
         if (ctl.fin) begin
            sample_ff <= sat;
            if (released_ff) rgain_ff <= dec[32:16];
            if (tick_ff + 1'b1 >= TW'(BLOCK_LEN)) begin
               lpeak_ff <= (mag > bpeak_ff) ? mag : bpeak_ff;
               if (bpeak_ff == '0 && mag == '0) silent_ff <= 1'b1;
               bpeak_ff <= '0;
               tick_ff <= '0;
            end else begin
               if (mag > bpeak_ff) bpeak_ff <= mag;
               tick_ff <= tick_ff + 1'b1;
            end
         end
      end
   end

   assign sample_out = sample_ff;
   assign finished = silent_ff || (released_ff && rgain_ff == '0);
   assign level = lpeak_ff;
endmodule
`default_nettype wire

// ===== hdl/ksds_ctrl.sv =====
// ---------------------------------------------------------------------------
// Dual string controller
// Sequences each word through the datapath and runs the handshakes.
// ---------------------------------------------------------------------------
`default_nettype none
module ksds_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_cmd,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ksds_pkg::ctl_type      ctl
);
   import ksds_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RD   = 6'b000010,
      ST_FILT = 6'b000100,
      ST_FBK  = 6'b001000,
      ST_MIX  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic rv_ff, rv_in;
   logic acc;
   cmd_type cmd;

   assign cmd = cmd_type'(req_cmd);
   // A new word enters only when idle and the result register is empty or
   // being taken in the same cycle.
   assign req_stall = (state_ff != ST_IDLE) || (rv_ff && rsp_stall);
   assign acc = req_valid && !req_stall;
   assign rsp_valid = rv_ff;

   always_comb begin
      ctl = '0;
      state_in = state_ff;
      rv_in = rv_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               unique case (cmd)
                  CMD_LOAD:    begin ctl.load = 1'b1; rv_in = 1'b1; end
                  CMD_RELEASE: begin ctl.release_n = 1'b1; rv_in = 1'b1; end
                  CMD_START:   begin ctl.start = 1'b1; rv_in = 1'b1; end
                  CMD_TICK:    begin ctl.rd = 1'b1; state_in = ST_RD; end
                  default:     ;
               endcase
            end
         end
         ST_RD:   begin ctl.filt = 1'b1; state_in = ST_FILT; end
         ST_FILT: begin ctl.fbk = 1'b1; state_in = ST_FBK; end
         ST_FBK:  begin ctl.mix = 1'b1; state_in = ST_MIX; end
         ST_MIX:  begin
            if (!(rv_ff && rsp_stall)) begin
               ctl.fin = 1'b1; rv_in = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
   end
endmodule
`default_nettype wire
